// File: hw/rtl/hopfield_associative_memory_defines.svh
// Assertion macros used by the checker of the associative memory.
`ifndef HOPFIELD_ASSOCIATIVE_MEMORY_DEFINES_SVH
`define HOPFIELD_ASSOCIATIVE_MEMORY_DEFINES_SVH

// Checked property on the rising clock, ignored while reset is asserted.
`define HOPF_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked property on the rising clock, also active during reset.
`define HOPF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hw/rtl/hopf_pkg.sv
// Shared constants, types and helper functions of the associative memory.
package hopf_pkg;

    localparam int NEURONS      = 16;
    localparam int WEIGHT_LIMIT = 15;
    localparam int PATTERN_W    = 16;
    localparam int IDX_W        = $clog2(NEURONS);
    localparam int WEIGHT_W     = $clog2(WEIGHT_LIMIT + 1) + 1;
    localparam int SUM_W        = $clog2(NEURONS * WEIGHT_LIMIT + 1) + 1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_TRAIN  = 2'd1,
        OP_LOAD   = 2'd2,
        OP_UPDATE = 2'd3
    } op_t;

    typedef logic [IDX_W-1:0]            idx_t;
    typedef logic signed [WEIGHT_W-1:0]  weight_t;
    typedef logic signed [WEIGHT_W:0]    weight_wide_t;
    typedef logic signed [SUM_W-1:0]     sum_t;
    typedef logic [NEURONS-1:0]          nvec_t;
    typedef logic [PATTERN_W-1:0]        pat_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic clear;
        logic train;
        logic load;
        logic set_state;
        logic set_value;
        idx_t idx;
    } cell_ctrl_t;

    // Spread the input pattern over the neurons; neurons past the pattern read as -1.
    function automatic nvec_t unpack_pattern(pat_t bits);
        nvec_t v;
        v = '0;
        for (int k = 0; k < NEURONS; k++) begin
            if (k < PATTERN_W) begin
                v[k] = bits[k];
            end
        end
        return v;
    endfunction

    // Pack the neuron states into the result word; missing neurons read as 0.
    function automatic pat_t pack_states(nvec_t s);
        pat_t v;
        v = '0;
        for (int k = 0; k < PATTERN_W; k++) begin
            if (k < NEURONS) begin
                v[k] = s[k];
            end
        end
        return v;
    endfunction

endpackage

// File: hw/rtl/hopf_cell.sv
// One neuron cell: its state bit, its weight column and one stage of the sum chain.
module hopf_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hopf_pkg::cell_ctrl_t   ctrl,
    input  hopf_pkg::idx_t         cell_id,
    input  logic                   pattern_self,
    input  hopf_pkg::nvec_t        pattern_all,
    input  hopf_pkg::sum_t         sum_in,
    output hopf_pkg::sum_t         sum_out,
    output logic                   state_bit
);

    hopf_pkg::weight_t      w_reg  [hopf_pkg::NEURONS];
    hopf_pkg::weight_t      w_next [hopf_pkg::NEURONS];
    logic                   state_reg;
    logic                   state_next;
    hopf_pkg::sum_t         sum_reg;
    hopf_pkg::sum_t         sum_next;
    hopf_pkg::weight_t      w_sel;
    hopf_pkg::sum_t         w_ext;

    // Hebbian step toward agreement or disagreement, clamped at the weight limit.
    function automatic hopf_pkg::weight_t hebb_step(hopf_pkg::weight_t w, logic agree);
        hopf_pkg::weight_wide_t ext;
        hopf_pkg::weight_wide_t wide;
        hopf_pkg::weight_t      res;
        ext  = hopf_pkg::weight_wide_t'(w);
        wide = agree ? (ext + hopf_pkg::weight_wide_t'(1)) : (ext - hopf_pkg::weight_wide_t'(1));
        if (wide > hopf_pkg::weight_wide_t'(hopf_pkg::WEIGHT_LIMIT)) begin
            res = hopf_pkg::weight_t'(hopf_pkg::WEIGHT_LIMIT);
        end else if (wide < hopf_pkg::weight_wide_t'(-hopf_pkg::WEIGHT_LIMIT)) begin
            res = hopf_pkg::weight_t'(-hopf_pkg::WEIGHT_LIMIT);
        end else begin
            res = hopf_pkg::weight_t'(wide);
        end
        return res;
    endfunction

    // Weight column update: clear or train all rows at once, diagonal left at zero.
    always_comb begin
        for (int j = 0; j < hopf_pkg::NEURONS; j++) begin
            w_next[j] = w_reg[j];
            if (ctrl.clear) begin
                w_next[j] = '0;
            end else if (ctrl.train && (hopf_pkg::idx_t'(j) != cell_id)) begin
                w_next[j] = hebb_step(w_reg[j], pattern_all[j] == pattern_self);
            end
        end
    end

    // State bit: loaded from a pattern or written with an update result.
    always_comb begin
        state_next = state_reg;
        if (ctrl.load) begin
            state_next = pattern_self;
        end else if (ctrl.set_state && (ctrl.idx == cell_id)) begin
            state_next = ctrl.set_value;
        end
    end

    // This cell's signed term for the selected row, added to the running sum.
    assign w_sel    = w_reg[ctrl.idx];
    assign w_ext    = hopf_pkg::sum_t'(w_sel);
    assign sum_next = sum_in + (state_reg ? w_ext : -w_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= 1'b0;
            for (int j = 0; j < hopf_pkg::NEURONS; j++) begin
                w_reg[j] <= '0;
            end
        end else begin
            state_reg <= state_next;
            for (int j = 0; j < hopf_pkg::NEURONS; j++) begin
                w_reg[j] <= w_next[j];
            end
        end
    end

    // The partial sum moves one cell down the chain every cycle.
    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign sum_out   = sum_reg;
    assign state_bit = state_reg;

endmodule

// File: hw/rtl/hopfield_associative_memory.sv
// Top level of the associative memory: sequencer, result register and the chain of cells.
//
//   channel | direction | ports                                              | beat
//   s_      | in        | s_valid s_ready s_operation s_neuron_index s_pattern_bits | one op
//   m_      | out       | m_valid m_ready m_changed m_state_bits             | one result
//
// Clear, train and load go from accept straight to the finish state; an in-range update first
// runs while the partial sum passes through the NEURONS cells one cell per cycle.
// Synchronous active-low reset zeroes all weights and states at once; no clearing pass.
// A new beat is taken while the previous result still waits on m_ready; a finished
// item then holds in its last step until the result register is free.
module hopfield_associative_memory (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [3:0]  s_neuron_index,
    input  logic [15:0] s_pattern_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_changed,
    output logic [15:0] m_state_bits
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } fsm_t;

    fsm_t                  fsm_reg, fsm_next;
    logic                  upd_reg, upd_next;
    hopf_pkg::idx_t        idx_reg, idx_next;
    hopf_pkg::idx_t        cnt_reg, cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_changed_reg, m_changed_next;
    hopf_pkg::pat_t        m_state_bits_reg, m_state_bits_next;

    logic                  s_fire;
    hopf_pkg::op_t         op;
    logic                  in_range;
    logic                  finish_go;
    logic                  next_val;
    logic                  changed_now;
    hopf_pkg::nvec_t       pat_vec;
    hopf_pkg::nvec_t       state_vec;
    hopf_pkg::nvec_t       new_states;
    hopf_pkg::cell_ctrl_t  ctrl;
    hopf_pkg::sum_t        chain [hopf_pkg::NEURONS + 1];

    assign s_ready   = (fsm_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign op        = hopf_pkg::op_t'(s_operation);
    assign in_range  = int'(s_neuron_index) < hopf_pkg::NEURONS;
    assign pat_vec   = hopf_pkg::unpack_pattern(s_pattern_bits);
    assign finish_go = (fsm_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    // Sign decision at the end of the chain and the resulting state vector.
    assign next_val    = chain[hopf_pkg::NEURONS] > hopf_pkg::sum_t'(0);
    assign changed_now = upd_reg && (next_val != state_vec[idx_reg]);

    always_comb begin
        new_states = state_vec;
        if (upd_reg) begin
            new_states[idx_reg] = next_val;
        end
    end

    // Broadcast control to the cells.
    always_comb begin
        ctrl.clear     = s_fire && (op == hopf_pkg::OP_CLEAR);
        ctrl.train     = s_fire && (op == hopf_pkg::OP_TRAIN);
        ctrl.load      = s_fire && (op == hopf_pkg::OP_LOAD);
        ctrl.set_state = finish_go && upd_reg;
        ctrl.set_value = next_val;
        ctrl.idx       = idx_reg;
    end

    // Chain of neuron cells; the sum enters at cell 0 as zero.
    assign chain[0] = '0;

    for (genvar k = 0; k < hopf_pkg::NEURONS; k++) begin : g_cell
        hopf_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .cell_id      (hopf_pkg::idx_t'(k)),
            .pattern_self (pat_vec[k]),
            .pattern_all  (pat_vec),
            .sum_in       (chain[k]),
            .sum_out      (chain[k + 1]),
            .state_bit    (state_vec[k])
        );
    end

    // Sequencer and result register next values.
    always_comb begin
        fsm_next          = fsm_reg;
        upd_next          = upd_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_changed_next    = m_changed_reg;
        m_state_bits_next = m_state_bits_reg;
        case (fsm_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    upd_next = (op == hopf_pkg::OP_UPDATE) && in_range;
                    idx_next = hopf_pkg::idx_t'(s_neuron_index);
                    cnt_next = '0;
                    fsm_next = ((op == hopf_pkg::OP_UPDATE) && in_range) ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN: begin
                cnt_next = cnt_reg + hopf_pkg::idx_t'(1);
                if (cnt_reg == hopf_pkg::idx_t'(hopf_pkg::NEURONS - 1)) begin
                    fsm_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (finish_go) begin
                    fsm_next          = ST_IDLE;
                    m_valid_next      = 1'b1;
                    m_changed_next    = changed_now;
                    m_state_bits_next = hopf_pkg::pack_states(new_states);
                end
            end
            default: begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            fsm_reg     <= fsm_next;
            m_valid_reg <= m_valid_next;
        end
        upd_reg          <= upd_next;
        idx_reg          <= idx_next;
        cnt_reg          <= cnt_next;
        m_changed_reg    <= m_changed_next;
        m_state_bits_reg <= m_state_bits_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_changed    = m_changed_reg;
    assign m_state_bits = m_state_bits_reg;

endmodule

// File: hw/rtl/hopf_checker.sv
// Port-level checker for the associative memory, bound to the top level.
`include "hopfield_associative_memory_defines.svh"

module hopf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_operation,
    input logic [3:0]  s_neuron_index,
    input logic [15:0] s_pattern_bits,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_changed,
    input logic [15:0] m_state_bits
);

    // A stalled result beat keeps its payload.
    `HOPF_ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_changed) && $stable(m_state_bits), "result beat changed while stalled")

    // Reset empties the result register.
    `HOPF_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid right after reset")

    // Only one item is in work at a time.
    `HOPF_ASSERT_CLK(a_one_item, s_valid && s_ready |=> !s_ready, "input taken while an item is in work")

    // Clear, train and load, accepted with the result register empty, give a result that never reports a flip.
    `HOPF_ASSERT_CLK(a_fast_ops, s_valid && s_ready && !m_valid && (s_operation != hopf_pkg::OP_UPDATE) |-> ##2 (m_valid && !m_changed), "non-update beat result missing or flagged")

endmodule

bind hopfield_associative_memory hopf_checker u_hopf_checker (.*);
